// ----- hw/rtl/multidim_bin_category_macros.svh -----
// Assertion macros for the multidimensional bin category block
`ifndef MULTIDIM_BIN_CATEGORY_MACROS_SVH
`define MULTIDIM_BIN_CATEGORY_MACROS_SVH

// Clocked assertion with asynchronous active-low reset
`define MDBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the next cycle
`define MDBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/mdbc_pkg.sv -----
// Package of types and constants for the multidimensional bin category block
`default_nettype none
package mdbc_pkg;
  localparam int unsigned MAX_VARS_DEF  = 3;
  localparam int unsigned MAX_EDGES_DEF = 16;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned SLOT_W        = 2;
  localparam int unsigned EIDX_W        = 4;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned CAT_W         = 12;
  localparam int unsigned BIN_W         = 4;
  localparam int unsigned NV_W          = 2;
  localparam int unsigned NE_W          = 5;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_DECODE   = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_VARS = 2'd0,
    CFG_EDGES0   = 2'd1,
    CFG_EDGES1   = 2'd2,
    CFG_EDGES2   = 2'd3
  } cfg_idx_e;
endpackage
`default_nettype wire

// ----- hw/rtl/mdbc_intf.sv -----
// Channel interfaces for input items, results and configuration writes
`default_nettype none
interface mdbc_in_if;
  import mdbc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [SLOT_W-1:0]        slot;
  logic [EIDX_W-1:0]        edge_index;
  logic signed [VAL_W-1:0]  edge_value;
  logic signed [VAL_W-1:0]  value_0;
  logic signed [VAL_W-1:0]  value_1;
  logic signed [VAL_W-1:0]  value_2;
  logic [CAT_W-1:0]         category_in;
  modport source (output valid, op, slot, edge_index, edge_value, value_0, value_1, value_2,
                  category_in, input ready);
  modport sink   (input valid, op, slot, edge_index, edge_value, value_0, value_1, value_2,
                  category_in, output ready);
endinterface

interface mdbc_out_if;
  import mdbc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     in_range;
  logic [CAT_W-1:0]         category;
  logic [SLOT_W-1:0]        out_slot;
  logic [BIN_W-1:0]         bin;
  logic signed [VAL_W-1:0]  bin_center;
  logic                     last;
  modport source (output valid, in_range, category, out_slot, bin, bin_center, last,
                  input ready);
  modport sink   (input valid, in_range, category, out_slot, bin, bin_center, last,
                  output ready);
endinterface

interface mdbc_cfg_if;
  import mdbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/multidim_bin_category.sv -----
// Top level of the multidimensional bin category block
//
// Channel  Dir  Handshake     Carries
// in_i     in   valid/ready   op, slot, edge_index, edge_value, value_0..2, category_in
// res_o    out  valid/ready   in_range, category, out_slot, bin, bin_center, last
// cfg_i    in   valid/ready   index, data (ready always high)
//
// Edge write: stored as the item is accepted. Classify: a read step and a compare step per edge
// in use over all slots, then an emit step. Decode: the shared restoring divider runs per slot,
// then per result two reads of the edge memory's read port, an add and an emit step.
// One item at a time; in_i.ready is high only while idle. A stalled result holds the
// sequencer in its emit step. Reset clears control state; the edge memory is not cleared.
`default_nettype none
module multidim_bin_category #(
  parameter int unsigned MAX_VARS  = mdbc_pkg::MAX_VARS_DEF,
  parameter int unsigned MAX_EDGES = mdbc_pkg::MAX_EDGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdbc_in_if.sink     in_i,
  mdbc_out_if.source  res_o,
  mdbc_cfg_if.sink    cfg_i
);
  import mdbc_pkg::*;

  localparam int unsigned DEPTH = MAX_VARS * MAX_EDGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = $clog2(MAX_EDGES);
  localparam int unsigned CW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned DCW   = $clog2(CAT_W);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CRD    = 8'b0000_0010,
    ST_CCMP   = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_DRD_LO = 8'b0001_0000,
    ST_DRD_HI = 8'b0010_0000,
    ST_DSUM   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [SLOT_W-1:0]       s_q, s_d;
  logic [EW-1:0]           i_q, i_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    ok_q, ok_d;
  logic [CAT_W-1:0]        cat_q, cat_d;
  logic [CAT_W-1:0]        quo_q, quo_d;
  logic [CW-1:0]           rem_q, rem_d;
  logic [DCW-1:0]          dcnt_q, dcnt_d;
  logic                    dec_q, dec_d;
  logic [VAL_W-1:0]        val_q [3];
  logic [BIN_W-1:0]        bins_q [3];
  logic [VAL_W-1:0]        lo_q;
  logic [VAL_W-1:0]        center_q;

  logic [NV_W-1:0]         num_vars_q;
  logic [NE_W-1:0]         edges_q [3];
  logic [NV_W-1:0]         nv;
  logic [CW-1:0]           ne [3];

  logic                    out_valid_q, out_in_range_q, out_last_q;
  logic [CAT_W-1:0]        out_cat_q;
  logic [SLOT_W-1:0]       out_slot_q;
  logic [BIN_W-1:0]        out_bin_q;
  logic [VAL_W-1:0]        out_center_q;

  logic [VAL_W-1:0]        mem [DEPTH];
  logic [VAL_W-1:0]        rdata_q;
  logic [AW-1:0]           raddr, waddr;
  logic                    re, we;

  logic                    in_acc, out_free;
  op_e                     op;
  logic                    ge, slot_done, last_slot, emit_last;
  logic [CW-1:0]           cnt_n, nb;
  logic [CW:0]             rr;
  logic [VAL_W:0]          sum;
  logic                    load_bin;

  assign op        = op_e'(in_i.op);
  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free  = !out_valid_q || res_o.ready;

  assign nv = (32'(num_vars_q) > MAX_VARS) ? NV_W'(MAX_VARS) : num_vars_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (edges_q[k] < NE_W'(2)) begin
        ne[k] = CW'(2);
      end else if (32'(edges_q[k]) > MAX_EDGES) begin
        ne[k] = CW'(MAX_EDGES);
      end else begin
        ne[k] = CW'(edges_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q <= '0;
      edges_q[0] <= NE_W'(2);
      edges_q[1] <= NE_W'(2);
      edges_q[2] <= NE_W'(2);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_NUM_VARS: num_vars_q <= cfg_i.data[NV_W-1:0];
        CFG_EDGES0:   edges_q[0] <= cfg_i.data;
        CFG_EDGES1:   edges_q[1] <= cfg_i.data;
        CFG_EDGES2:   edges_q[2] <= cfg_i.data;
        default:      num_vars_q <= num_vars_q;
      endcase
    end
  end

  // Edge memory: one write port, one registered read port
  assign we    = in_acc && (op == OP_WRITE) && (32'(in_i.slot) < MAX_VARS)
                 && (32'(in_i.edge_index) < MAX_EDGES);
  assign waddr = AW'(32'(in_i.slot) * MAX_EDGES + 32'(in_i.edge_index));

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    case (state_q)
      ST_CRD: begin
        re    = 1'b1;
        raddr = AW'(32'(s_q) * MAX_EDGES + 32'(i_q));
      end
      ST_DRD_LO: begin
        re    = 1'b1;
        raddr = AW'(32'(s_q) * MAX_EDGES + 32'(bins_q[s_q]));
      end
      ST_DRD_HI: begin
        re    = 1'b1;
        raddr = AW'(32'(s_q) * MAX_EDGES + 32'(bins_q[s_q]) + 32'd1);
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_i.edge_value;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Shared datapath terms
  assign ge        = ($signed(rdata_q) <= $signed(val_q[s_q]));
  assign cnt_n     = cnt_q + CW'(ge);
  assign slot_done = (CW'(i_q) == ne[s_q] - CW'(1));
  assign last_slot = (s_q == nv - NV_W'(1));
  assign nb        = ne[s_q] - CW'(1);
  assign rr        = {rem_q, quo_q[CAT_W-1]};
  assign sum       = {lo_q[VAL_W-1], lo_q} + {rdata_q[VAL_W-1], rdata_q};
  assign emit_last = !dec_q || last_slot;
  assign load_bin  = (state_q == ST_DIV) && (dcnt_q == DCW'(CAT_W - 1));

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    ok_d    = ok_q;
    cat_d   = cat_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dcnt_d  = dcnt_q;
    dec_d   = dec_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op == OP_CLASSIFY)) begin
          dec_d = 1'b0;
          s_d   = '0;
          i_d   = '0;
          cnt_d = '0;
          cat_d = '0;
          ok_d  = (nv != '0);
          state_d = (nv == '0) ? ST_EMIT : ST_CRD;
        end else if (in_acc && (op == OP_DECODE) && (nv != '0)) begin
          dec_d   = 1'b1;
          s_d     = SLOT_W'(nv - NV_W'(1));
          quo_d   = in_i.category_in;
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_CRD: begin
        state_d = ST_CCMP;
      end
      ST_CCMP: begin
        if (slot_done) begin
          if ((cnt_n == '0) || (cnt_n == ne[s_q])) begin
            ok_d = 1'b0;
          end else begin
            cat_d = CAT_W'(cat_q * nb + CAT_W'(cnt_n - CW'(1)));
          end
          cnt_d = '0;
          i_d   = '0;
          if (last_slot) begin
            state_d = ST_EMIT;
          end else begin
            s_d     = s_q + SLOT_W'(1);
            state_d = ST_CRD;
          end
        end else begin
          cnt_d   = cnt_n;
          i_d     = i_q + EW'(1);
          state_d = ST_CRD;
        end
      end
      ST_DIV: begin
        if (rr >= {1'b0, nb}) begin
          rem_d = CW'(rr - {1'b0, nb});
          quo_d = {quo_q[CAT_W-2:0], 1'b1};
        end else begin
          rem_d = CW'(rr);
          quo_d = {quo_q[CAT_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCW'(1);
        if (load_bin) begin
          rem_d  = '0;
          dcnt_d = '0;
          if (s_q == '0) begin
            state_d = ST_DRD_LO;
          end else begin
            s_d = s_q - SLOT_W'(1);
          end
        end
      end
      ST_DRD_LO: begin
        state_d = ST_DRD_HI;
      end
      ST_DRD_HI: begin
        state_d = ST_DSUM;
      end
      ST_DSUM: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            s_d     = s_q + SLOT_W'(1);
            state_d = ST_DRD_LO;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s_q     <= '0;
      i_q     <= '0;
      cnt_q   <= '0;
      ok_q    <= 1'b0;
      cat_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dcnt_q  <= '0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      ok_q    <= ok_d;
      cat_q   <= cat_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      dcnt_q  <= dcnt_d;
      dec_q   <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (op == OP_CLASSIFY)) begin
      val_q[0] <= in_i.value_0;
      val_q[1] <= in_i.value_1;
      val_q[2] <= in_i.value_2;
    end
    if (load_bin) begin
      bins_q[s_q] <= BIN_W'(rr >= {1'b0, nb} ? rr - {1'b0, nb} : rr);
    end
    if (state_q == ST_DRD_HI) begin
      lo_q <= rdata_q;
    end
    if (state_q == ST_DSUM) begin
      center_q <= sum[VAL_W:1];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_free) begin
      out_in_range_q <= !dec_q && ok_q;
      out_cat_q      <= (!dec_q && ok_q) ? cat_q : '0;
      out_slot_q     <= dec_q ? s_q : '0;
      out_bin_q      <= dec_q ? bins_q[s_q] : '0;
      out_center_q   <= dec_q ? center_q : '0;
      out_last_q     <= emit_last;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.in_range   = out_in_range_q;
  assign res_o.category   = out_cat_q;
  assign res_o.out_slot   = out_slot_q;
  assign res_o.bin        = out_bin_q;
  assign res_o.bin_center = out_center_q;
  assign res_o.last       = out_last_q;
endmodule
`default_nettype wire

// ----- hw/rtl/mdbc_chk.sv -----
// Port checker for the multidimensional bin category block, with its bind
`default_nettype none
`include "multidim_bin_category_macros.svh"
module mdbc_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [mdbc_pkg::OP_W-1:0]    in_op,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_in_range,
  input logic [mdbc_pkg::CAT_W-1:0]   res_category,
  input logic [mdbc_pkg::BIN_W-1:0]   res_bin
);
  import mdbc_pkg::*;

  `MDBC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready, res_valid, "result dropped while stalled")
  `MDBC_ASSERT_NEXT(a_busy_after_classify, clk_i, rst_ni, in_valid && in_ready && (in_op == OP_CLASSIFY), !in_ready, "ready while classifying")
  `MDBC_ASSERT(a_out_range_zero, clk_i, rst_ni, (res_valid && !res_in_range) |-> (res_category == '0), "category set while out of range")
  `MDBC_ASSERT(a_classify_no_bin, clk_i, rst_ni, (res_valid && res_in_range) |-> (res_bin == '0), "bin set on a classify result")
endmodule

bind multidim_bin_category mdbc_chk u_mdbc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_op        (in_i.op),
  .res_valid    (res_o.valid),
  .res_ready    (res_o.ready),
  .res_in_range (res_o.in_range),
  .res_category (res_o.category),
  .res_bin      (res_o.bin)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the multidimensional bin category block
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import mdbc_pkg::*;

  localparam int unsigned N_SLOTS   = MAX_VARS_DEF;
  localparam int unsigned N_EDGES   = MAX_EDGES_DEF;
  localparam int unsigned CYC_LIMIT = 400000;
  localparam int unsigned DRAIN_CYC = 40;

  typedef struct {
    op_e                      op;
    logic [SLOT_W-1:0]        slot;
    logic [EIDX_W-1:0]        edge_index;
    logic signed [VAL_W-1:0]  edge_value;
    logic signed [VAL_W-1:0]  value [N_SLOTS];
    logic [CAT_W-1:0]         category_in;
  } bin_item_t;

  typedef struct packed {
    logic                     in_range;
    logic [CAT_W-1:0]         category;
    logic [SLOT_W-1:0]        out_slot;
    logic [BIN_W-1:0]         bin;
    logic signed [VAL_W-1:0]  bin_center;
    logic                     last;
  } bin_result_t;

  logic clk;
  logic rst_n;

  mdbc_in_if  in_bus ();
  mdbc_out_if res_bus ();
  mdbc_cfg_if cfg_bus ();

  multidim_bin_category u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  logic signed [VAL_W-1:0] edge_mirror [N_SLOTS*N_EDGES];
  logic [NV_W-1:0]         vars_in_use;
  logic [NE_W-1:0]         edges_in_use [N_SLOTS];

  bin_result_t pending_results [$];
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned item_cnt;
  int unsigned result_cnt;
  bit          quiet;
  bit          hold_off;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("%0t timeout after %0d cycles", $realtime, cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned slot_edges(int unsigned s);
    int unsigned n;
    n = edges_in_use[s];
    if (n < 2) n = 2;
    if (n > N_EDGES) n = N_EDGES;
    return n;
  endfunction

  function automatic void queue_result(bin_result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict_bins(bin_item_t it);
    int unsigned nv, n, cnt, norm, nb, b;
    logic [31:0] cat;
    bit ok;
    logic signed [VAL_W:0] sum;
    bin_result_t r;
    nv = vars_in_use;
    if (nv > N_SLOTS) nv = N_SLOTS;
    case (it.op)
      OP_WRITE: begin
        if (it.slot < N_SLOTS) edge_mirror[it.slot*N_EDGES + it.edge_index] = it.edge_value;
      end
      OP_CLASSIFY: begin
        ok = nv > 0;
        cat = 0;
        for (int unsigned s = 0; s < nv; s++) begin
          n = slot_edges(s);
          cnt = 0;
          for (int unsigned i = 0; i < n; i++)
            if (edge_mirror[s*N_EDGES + i] <= it.value[s]) cnt++;
          if (cnt == 0 || cnt == n) ok = 0;
          else cat = cat * (n - 1) + (cnt - 1);
        end
        r = '0;
        r.in_range = ok;
        r.category = ok ? cat[CAT_W-1:0] : '0;
        r.last = 1'b1;
        queue_result(r);
      end
      OP_DECODE: begin
        for (int unsigned s = 0; s < nv; s++) begin
          norm = 1;
          for (int unsigned j = s + 1; j < nv; j++) norm *= slot_edges(j) - 1;
          nb = slot_edges(s) - 1;
          b = (it.category_in / norm) % nb;
          sum = {edge_mirror[s*N_EDGES + b][VAL_W-1], edge_mirror[s*N_EDGES + b]}
              + {edge_mirror[s*N_EDGES + b + 1][VAL_W-1], edge_mirror[s*N_EDGES + b + 1]};
          r = '0;
          r.out_slot = s[SLOT_W-1:0];
          r.bin = b[BIN_W-1:0];
          r.bin_center = sum[VAL_W:1];
          r.last = (s + 1 == nv);
          queue_result(r);
        end
      end
      default: ;
    endcase
  endfunction

  // sender: drive at the falling edge, count acceptance at the rising edge
  task automatic send_item(bin_item_t it);
    int unsigned gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.op          = it.op;
    in_bus.slot        = it.slot;
    in_bus.edge_index  = it.edge_index;
    in_bus.edge_value  = it.edge_value;
    in_bus.value_0     = it.value[0];
    in_bus.value_1     = it.value[1];
    in_bus.value_2     = it.value[2];
    in_bus.category_in = it.category_in;
    in_bus.valid       = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    predict_bins(it);
    item_cnt++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic wait_idle();
    drop_valid();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_NUM_VARS: vars_in_use = data[NV_W-1:0];
      CFG_EDGES0:   edges_in_use[0] = data;
      CFG_EDGES1:   edges_in_use[1] = data;
      default:      edges_in_use[2] = data;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_layout(int unsigned nv, int unsigned e0, int unsigned e1, int unsigned e2);
    wait_idle();
    write_cfg(CFG_NUM_VARS, nv[CFG_DATA_W-1:0]);
    write_cfg(CFG_EDGES0, e0[CFG_DATA_W-1:0]);
    write_cfg(CFG_EDGES1, e1[CFG_DATA_W-1:0]);
    write_cfg(CFG_EDGES2, e2[CFG_DATA_W-1:0]);
  endtask

  function automatic bin_item_t blank_item(op_e op);
    bin_item_t it;
    it.op = op;
    it.slot = SLOT_W'($urandom);
    it.edge_index = EIDX_W'($urandom);
    it.edge_value = $urandom;
    for (int s = 0; s < N_SLOTS; s++) it.value[s] = $urandom;
    it.category_in = CAT_W'($urandom);
    return it;
  endfunction

  task automatic put_edge(int unsigned s, int unsigned i, logic signed [VAL_W-1:0] v);
    bin_item_t it;
    it = blank_item(OP_WRITE);
    it.slot = s[SLOT_W-1:0];
    it.edge_index = i[EIDX_W-1:0];
    it.edge_value = v;
    send_item(it);
  endtask

  task automatic load_sorted_slot(int unsigned s);
    logic signed [VAL_W-1:0] v;
    v = -32'sd2147483647 - 1 + $urandom_range(0, 32'h0FFF_FFFF);
    for (int unsigned i = 0; i < N_EDGES; i++) begin
      put_edge(s, i, v);
      v = v + $urandom_range(1, 32'h07FF_FFFF);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] near_edge(int unsigned s);
    int unsigned i;
    i = $urandom_range(0, slot_edges(s) - 1);
    case ($urandom_range(0, 4))
      0: return edge_mirror[s*N_EDGES + i] - 1;
      1: return edge_mirror[s*N_EDGES + i] + 1;
      2: return $urandom;
      default: return edge_mirror[s*N_EDGES + i];
    endcase
  endfunction

  task automatic send_classify();
    bin_item_t it;
    it = blank_item(OP_CLASSIFY);
    for (int unsigned s = 0; s < N_SLOTS; s++) it.value[s] = near_edge(s);
    send_item(it);
  endtask

  task automatic send_decode();
    bin_item_t it;
    it = blank_item(OP_DECODE);
    if ($urandom_range(0, 3) != 0) it.category_in = CAT_W'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic test_edge_table_load();
    for (int unsigned s = 0; s < N_SLOTS; s++) load_sorted_slot(s);
    put_edge(0, 0, -32'sd2147483647 - 1);
    put_edge(0, 15, 32'sd2147483647);
  endtask

  task automatic test_directed_ops();
    bin_item_t it;
    set_layout(3, 16, 2, 5);
    it = blank_item(OP_CLASSIFY);
    it.value[0] = -32'sd2147483647 - 1;
    it.value[1] = edge_mirror[N_EDGES];
    it.value[2] = edge_mirror[2*N_EDGES + 1];
    send_item(it);
    it.value[0] = 32'sd2147483647;
    send_item(it);
    it.value[0] = 32'sd2147483646;
    send_item(it);
    it.value[1] = edge_mirror[N_EDGES] - 1;
    send_item(it);
    it = blank_item(OP_DECODE);
    it.category_in = '0;
    send_item(it);
    it.category_in = '1;
    send_item(it);
    it = blank_item(OP_NONE);
    send_item(it);
    put_edge(3, 7, 32'h1234_5678);
    put_edge(1, 2, edge_mirror[N_EDGES + 1] + 1);
    send_classify();
    put_edge(2, 3, edge_mirror[2*N_EDGES]);
    put_edge(2, 0, edge_mirror[2*N_EDGES + 4] + 5);
    send_classify();
    send_decode();
    set_layout(0, 2, 2, 2);
    send_classify();
    send_decode();
  endtask

  task automatic test_config_clamp();
    set_layout(3, 0, 1, 31);
    send_classify();
    send_decode();
    set_layout(3, 17, 16, 2);
    send_classify();
    send_decode();
  endtask

  task automatic random_burst(int unsigned count);
    int unsigned pick;
    bin_item_t it;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_classify();
      else if (pick < 80) send_decode();
      else if (pick < 93) begin
        it = blank_item(OP_WRITE);
        it.slot = SLOT_W'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) it.edge_value = near_edge(it.slot);
        send_item(it);
      end else if (pick < 96) begin
        it = blank_item(OP_WRITE);
        it.slot = 2'd3;
        send_item(it);
      end else send_item(blank_item(OP_NONE));
    end
  endtask

  task automatic test_random();
    set_layout(3, 4, 3, 5);
    random_burst(25);
    set_layout(1, 16, 9, 9);
    random_burst(15);
    quiet = 1;
    set_layout(2, 2, 16, 7);
    random_burst(15);
    quiet = 0;
    set_layout(3, 16, 16, 16);
    random_burst(25);
    set_layout(0, 5, 5, 5);
    random_burst(5);
    set_layout(3, 2, 2, 2);
    random_burst(10);
  endtask

  task automatic test_backpressure();
    set_layout(3, 6, 5, 4);
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      random_burst(15);
    join
  endtask

  always @(negedge clk) begin
    if (hold_off) res_bus.ready <= 1'b0;
    else if (quiet) res_bus.ready <= 1'b1;
    else res_bus.ready <= ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    bin_result_t got, want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.in_range, res_bus.category, res_bus.out_slot, res_bus.bin,
              res_bus.bin_center, res_bus.last};
      result_cnt++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $realtime, got);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.in_range !== want.in_range) begin
          $display("%0t in_range exp %0d got %0d", $realtime, want.in_range, got.in_range);
          fail_cnt++;
        end
        if (got.category !== want.category) begin
          $display("%0t category exp %0d got %0d", $realtime, want.category, got.category);
          fail_cnt++;
        end
        if (got.out_slot !== want.out_slot) begin
          $display("%0t out_slot exp %0d got %0d", $realtime, want.out_slot, got.out_slot);
          fail_cnt++;
        end
        if (got.bin !== want.bin) begin
          $display("%0t bin exp %0d got %0d", $realtime, want.bin, got.bin);
          fail_cnt++;
        end
        if (got.bin_center !== want.bin_center) begin
          $display("%0t bin_center exp %h got %h", $realtime, want.bin_center,
                   got.bin_center);
          fail_cnt++;
        end
        if (got.last !== want.last) begin
          $display("%0t last exp %0d got %0d", $realtime, want.last, got.last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    fail_cnt = 0;
    item_cnt = 0;
    result_cnt = 0;
    quiet = 0;
    hold_off = 0;
    vars_in_use = '0;
    for (int s = 0; s < N_SLOTS; s++) edges_in_use[s] = 5'd2;
    in_bus.valid = 1'b0;
    in_bus.op = OP_NONE;
    in_bus.slot = '0;
    in_bus.edge_index = '0;
    in_bus.edge_value = '0;
    in_bus.value_0 = '0;
    in_bus.value_1 = '0;
    in_bus.value_2 = '0;
    in_bus.category_in = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_NUM_VARS;
    cfg_bus.data = '0;
    res_bus.ready = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_edge_table_load();
    test_directed_ops();
    test_config_clamp();
    test_random();
    test_backpressure();
    wait_idle();
    if (pending_results.size() != 0) begin
      $display("%0t %0d results never arrived", $realtime, pending_results.size());
      fail_cnt++;
    end
    $display("Covered %0d items and %0d results over edge writes, classify and decode,",
             item_cnt, result_cnt);
    $display("with clamped layouts, zero slots, ignored writes and a long output stall.");
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mdbc_pkg.sv
hw/rtl/mdbc_intf.sv
hw/rtl/multidim_bin_category.sv
hw/rtl/mdbc_chk.sv
bench/tb_top.sv
